// ----- rtl/sip_pkg.sv -----
package sip_pkg;

    // coordinate width, fixed by the payload structs
    localparam int COORD_BITS = 16;

    // derived widths
    localparam int DW   = COORD_BITS + 1;        // coordinate difference
    localparam int OPW  = 2 * COORD_BITS + 2;    // product of two differences
    localparam int OW   = 2 * COORD_BITS + 3;    // orientation value
    localparam int CW   = 2 * COORD_BITS + 2;    // line constant c
    localparam int DETW = 2 * COORD_BITS + 3;    // determinant
    localparam int PW   = DW + CW;               // numerator partial product
    localparam int NUMW = PW + 1;                // numerator
    localparam int QW   = COORD_BITS + 1;        // quotient bits kept

    // orientation codes
    localparam logic [1:0] ORI_COL = 2'd0;
    localparam logic [1:0] ORI_POS = 2'd1;
    localparam logic [1:0] ORI_NEG = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] seg1_start_x;
        logic signed [COORD_BITS-1:0] seg1_start_y;
        logic signed [COORD_BITS-1:0] seg1_end_x;
        logic signed [COORD_BITS-1:0] seg1_end_y;
        logic signed [COORD_BITS-1:0] seg2_start_x;
        logic signed [COORD_BITS-1:0] seg2_start_y;
        logic signed [COORD_BITS-1:0] seg2_end_x;
        logic signed [COORD_BITS-1:0] seg2_end_y;
    } sip_in_t;

    typedef struct packed {
        logic                         intersects;
        logic                         parallel;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
        logic                         clipped;
    } sip_out_t;

    // divider stage payload: both coordinates share one divisor
    typedef struct packed {
        logic            hit;
        logic            par;
        logic            neg_x;
        logic            neg_y;
        logic [NUMW-1:0] rem_x;
        logic [NUMW-1:0] rem_y;
        logic [DETW-1:0] den;
        logic [QW-1:0]   q_x;
        logic [QW-1:0]   q_y;
    } sip_div_t;

    // one restoring division step at quotient bit position sh
    function automatic sip_div_t div_step(sip_div_t d, int sh);
        sip_div_t        r;
        logic [NUMW-1:0] dv;
        r  = d;
        dv = NUMW'(d.den) << sh;
        if (d.rem_x >= dv) begin
            r.rem_x = d.rem_x - dv;
            r.q_x   = {d.q_x[QW-2:0], 1'b1};
        end else begin
            r.q_x   = {d.q_x[QW-2:0], 1'b0};
        end
        if (d.rem_y >= dv) begin
            r.rem_y = d.rem_y - dv;
            r.q_y   = {d.q_y[QW-2:0], 1'b1};
        end else begin
            r.q_y   = {d.q_y[QW-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ----- rtl/sip_div.sv -----
module sip_div
    import sip_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  sip_div_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output sip_div_t out_data
);

    // stage 0 holds the operands, stage k+1 holds the result of bit QW-1-k
    localparam int NST = QW + 1;

    sip_div_t       st_reg [NST];
    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    // per-stage ready: an empty stage always takes data
    always_comb begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            st_reg[0] <= in_data;
        end
        for (int k = 1; k < NST; k++) begin
            if (rdy[k]) begin
                st_reg[k] <= div_step(st_reg[k-1], QW - k);
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_data  = st_reg[NST-1];

endmodule

// ----- rtl/segment_intersection_point.sv -----
// Segment intersection with line crossing point.
//
// Input channel s_valid/s_ready/s_data carries two segments as signed
// endpoints; result channel m_valid/m_ready/m_data returns the intersect
// flag, the parallel flag, the crossing point of the carrying lines
// (truncated toward zero, saturated) and the clipped flag.
//
// Throughput: one item per cycle while m_ready is not held low. The pipeline
// is built from the six front stages (input register and arithmetic), an
// operand stage and one stage per quotient bit in the restoring divider,
// and the output register.
//
// Reset clears every stage valid bit; the pipeline comes up empty and
// ready. When the receiver holds m_ready low, the result stays in the
// output register and items keep moving up to the first full stage;
// s_ready drops only once every stage holds an item.
module segment_intersection_point
    import sip_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sip_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sip_out_t m_data
);

    localparam int NFS = 6;
    localparam logic [QW-1:0] HALF = QW'(1) << (COORD_BITS - 1);

    typedef struct packed {
        logic signed [DW-1:0]         a1, b1, a2, b2;
        logic signed [DW-1:0]         e1x, e1y, e2x, e2y, e3x, e3y, e4x, e4y;
        logic signed [COORD_BITS-1:0] ax, ay, cx, cy;
        logic [3:0]                   btw;
    } stb_t;

    typedef struct packed {
        logic signed [DW-1:0]  a1, b1, a2, b2;
        logic signed [OPW-1:0] p1x, p1y, p2x, p2y, p3x, p3y, p4x, p4y;
        logic signed [CW-1:0]  c1a, c1b, c2a, c2b;
        logic signed [OPW-1:0] da, db;
        logic [3:0]            btw;
    } stc_t;

    typedef struct packed {
        logic signed [DW-1:0]   a1, b1, a2, b2;
        logic signed [CW-1:0]   c1, c2;
        logic signed [DETW-1:0] det;
        logic                   hit;
    } std_t;

    typedef struct packed {
        logic signed [PW-1:0]   n1, n2, n3, n4;
        logic signed [DETW-1:0] det;
        logic                   hit;
    } ste_t;

    typedef struct packed {
        logic signed [NUMW-1:0] nx, ny;
        logic signed [DETW-1:0] det;
        logic                   hit;
    } stf_t;

    sip_in_t        sa_reg;
    stb_t           sb_reg;
    stc_t           sc_reg;
    std_t           sd_reg;
    ste_t           se_reg;
    stf_t           sf_reg;
    logic [NFS-1:0] v_reg;
    logic [NFS:0]   rdy;

    stb_t     sb_next;
    stc_t     sc_next;
    std_t     sd_next;
    ste_t     se_next;
    sip_div_t div_in;
    sip_div_t div_out;
    logic     div_in_ready;
    logic     div_out_valid;
    logic     div_out_ready;

    sip_out_t out_reg;
    sip_out_t out_next;
    logic     out_valid_reg;

    // front ready chain
    always_comb begin
        rdy[NFS] = div_in_ready;
        for (int k = NFS - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NFS; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // box test: q inside the box spanned by p and r
    function automatic logic in_box(
        logic signed [COORD_BITS-1:0] px, py, qx, qy, rx, ry);
        logic xok, yok;
        xok = (px < rx) ? (qx >= px && qx <= rx) : (qx >= rx && qx <= px);
        yok = (py < ry) ? (qy >= py && qy <= ry) : (qy >= ry && qy <= py);
        return xok && yok;
    endfunction

    function automatic logic [1:0] ori_code(logic signed [OW-1:0] v);
        logic [1:0] c;
        if (v == '0) begin
            c = ORI_COL;
        end else if (v > 0) begin
            c = ORI_POS;
        end else begin
            c = ORI_NEG;
        end
        return c;
    endfunction

    // stage B: differences and box tests
    always_comb begin
        sb_next.a1  = DW'(sa_reg.seg1_end_y) - DW'(sa_reg.seg1_start_y);
        sb_next.b1  = DW'(sa_reg.seg1_start_x) - DW'(sa_reg.seg1_end_x);
        sb_next.a2  = DW'(sa_reg.seg2_end_y) - DW'(sa_reg.seg2_start_y);
        sb_next.b2  = DW'(sa_reg.seg2_start_x) - DW'(sa_reg.seg2_end_x);
        sb_next.e1x = DW'(sa_reg.seg2_start_x) - DW'(sa_reg.seg1_end_x);
        sb_next.e1y = DW'(sa_reg.seg2_start_y) - DW'(sa_reg.seg1_end_y);
        sb_next.e2x = DW'(sa_reg.seg2_end_x) - DW'(sa_reg.seg1_end_x);
        sb_next.e2y = DW'(sa_reg.seg2_end_y) - DW'(sa_reg.seg1_end_y);
        sb_next.e3x = DW'(sa_reg.seg1_start_x) - DW'(sa_reg.seg2_end_x);
        sb_next.e3y = DW'(sa_reg.seg1_start_y) - DW'(sa_reg.seg2_end_y);
        sb_next.e4x = DW'(sa_reg.seg1_end_x) - DW'(sa_reg.seg2_end_x);
        sb_next.e4y = DW'(sa_reg.seg1_end_y) - DW'(sa_reg.seg2_end_y);
        sb_next.ax  = sa_reg.seg1_start_x;
        sb_next.ay  = sa_reg.seg1_start_y;
        sb_next.cx  = sa_reg.seg2_start_x;
        sb_next.cy  = sa_reg.seg2_start_y;
        sb_next.btw[0] = in_box(sa_reg.seg1_start_x, sa_reg.seg1_start_y,
                                sa_reg.seg2_start_x, sa_reg.seg2_start_y,
                                sa_reg.seg1_end_x, sa_reg.seg1_end_y);
        sb_next.btw[1] = in_box(sa_reg.seg1_start_x, sa_reg.seg1_start_y,
                                sa_reg.seg2_end_x, sa_reg.seg2_end_y,
                                sa_reg.seg1_end_x, sa_reg.seg1_end_y);
        sb_next.btw[2] = in_box(sa_reg.seg2_start_x, sa_reg.seg2_start_y,
                                sa_reg.seg1_start_x, sa_reg.seg1_start_y,
                                sa_reg.seg2_end_x, sa_reg.seg2_end_y);
        sb_next.btw[3] = in_box(sa_reg.seg2_start_x, sa_reg.seg2_start_y,
                                sa_reg.seg1_end_x, sa_reg.seg1_end_y,
                                sa_reg.seg2_end_x, sa_reg.seg2_end_y);
    end

    // stage C: first products
    always_comb begin
        sc_next.a1  = sb_reg.a1;
        sc_next.b1  = sb_reg.b1;
        sc_next.a2  = sb_reg.a2;
        sc_next.b2  = sb_reg.b2;
        sc_next.p1x = OPW'(sb_reg.a1) * OPW'(sb_reg.e1x);
        sc_next.p1y = OPW'(sb_reg.b1) * OPW'(sb_reg.e1y);
        sc_next.p2x = OPW'(sb_reg.a1) * OPW'(sb_reg.e2x);
        sc_next.p2y = OPW'(sb_reg.b1) * OPW'(sb_reg.e2y);
        sc_next.p3x = OPW'(sb_reg.a2) * OPW'(sb_reg.e3x);
        sc_next.p3y = OPW'(sb_reg.b2) * OPW'(sb_reg.e3y);
        sc_next.p4x = OPW'(sb_reg.a2) * OPW'(sb_reg.e4x);
        sc_next.p4y = OPW'(sb_reg.b2) * OPW'(sb_reg.e4y);
        sc_next.c1a = CW'(sb_reg.a1) * CW'(sb_reg.ax);
        sc_next.c1b = CW'(sb_reg.b1) * CW'(sb_reg.ay);
        sc_next.c2a = CW'(sb_reg.a2) * CW'(sb_reg.cx);
        sc_next.c2b = CW'(sb_reg.b2) * CW'(sb_reg.cy);
        sc_next.da  = OPW'(sb_reg.a1) * OPW'(sb_reg.b2);
        sc_next.db  = OPW'(sb_reg.a2) * OPW'(sb_reg.b1);
        sc_next.btw = sb_reg.btw;
    end

    // stage D: orientation signs, hit decision, line constants, determinant
    always_comb begin
        logic [1:0] o1, o2, o3, o4;
        o1 = ori_code(OW'(sc_reg.p1x) + OW'(sc_reg.p1y));
        o2 = ori_code(OW'(sc_reg.p2x) + OW'(sc_reg.p2y));
        o3 = ori_code(OW'(sc_reg.p3x) + OW'(sc_reg.p3y));
        o4 = ori_code(OW'(sc_reg.p4x) + OW'(sc_reg.p4y));
        sd_next.a1  = sc_reg.a1;
        sd_next.b1  = sc_reg.b1;
        sd_next.a2  = sc_reg.a2;
        sd_next.b2  = sc_reg.b2;
        sd_next.c1  = sc_reg.c1a + sc_reg.c1b;
        sd_next.c2  = sc_reg.c2a + sc_reg.c2b;
        sd_next.det = DETW'(sc_reg.da) - DETW'(sc_reg.db);
        sd_next.hit = (o1 != o2 && o3 != o4)
                   || (o1 == ORI_COL && sc_reg.btw[0])
                   || (o2 == ORI_COL && sc_reg.btw[1])
                   || (o3 == ORI_COL && sc_reg.btw[2])
                   || (o4 == ORI_COL && sc_reg.btw[3]);
    end

    // stage E: numerator products
    always_comb begin
        se_next.n1  = PW'(sd_reg.b2) * PW'(sd_reg.c1);
        se_next.n2  = PW'(sd_reg.b1) * PW'(sd_reg.c2);
        se_next.n3  = PW'(sd_reg.a1) * PW'(sd_reg.c2);
        se_next.n4  = PW'(sd_reg.a2) * PW'(sd_reg.c1);
        se_next.det = sd_reg.det;
        se_next.hit = sd_reg.hit;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            sa_reg <= s_data;
        end
        if (rdy[1]) begin
            sb_reg <= sb_next;
        end
        if (rdy[2]) begin
            sc_reg <= sc_next;
        end
        if (rdy[3]) begin
            sd_reg <= sd_next;
        end
        if (rdy[4]) begin
            se_reg <= se_next;
        end
        if (rdy[5]) begin
            sf_reg.nx  <= NUMW'(se_reg.n1) - NUMW'(se_reg.n2);
            sf_reg.ny  <= NUMW'(se_reg.n3) - NUMW'(se_reg.n4);
            sf_reg.det <= se_reg.det;
            sf_reg.hit <= se_reg.hit;
        end
    end

    // magnitudes and quotient signs for the divider
    always_comb begin
        logic dneg;
        dneg         = sf_reg.det[DETW-1];
        div_in.hit   = sf_reg.hit;
        div_in.par   = (sf_reg.det == '0);
        div_in.neg_x = sf_reg.nx[NUMW-1] ^ dneg;
        div_in.neg_y = sf_reg.ny[NUMW-1] ^ dneg;
        div_in.rem_x = sf_reg.nx[NUMW-1] ? NUMW'(-sf_reg.nx) : NUMW'(sf_reg.nx);
        div_in.rem_y = sf_reg.ny[NUMW-1] ? NUMW'(-sf_reg.ny) : NUMW'(sf_reg.ny);
        div_in.den   = dneg ? DETW'(-sf_reg.det) : DETW'(sf_reg.det);
        div_in.q_x   = '0;
        div_in.q_y   = '0;
    end

    sip_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v_reg[NFS-1]),
        .in_ready  (div_in_ready),
        .in_data   (div_in),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_data  (div_out)
    );

    // saturation and parallel override
    always_comb begin
        logic cx, cy;
        cx = 1'b0;
        cy = 1'b0;
        out_next.intersects = div_out.hit;
        out_next.parallel   = div_out.par;
        if (div_out.neg_x) begin
            cx = (div_out.q_x > HALF);
            out_next.cross_x = cx ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                  : COORD_BITS'(-div_out.q_x);
        end else begin
            cx = (div_out.q_x > HALF - 1'b1);
            out_next.cross_x = cx ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                  : COORD_BITS'(div_out.q_x);
        end
        if (div_out.neg_y) begin
            cy = (div_out.q_y > HALF);
            out_next.cross_y = cy ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                  : COORD_BITS'(-div_out.q_y);
        end else begin
            cy = (div_out.q_y > HALF - 1'b1);
            out_next.cross_y = cy ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                  : COORD_BITS'(div_out.q_y);
        end
        out_next.clipped = cx || cy;
        if (div_out.par) begin
            out_next.cross_x = '1;
            out_next.cross_y = '1;
            out_next.clipped = 1'b0;
        end
    end

    // output register
    assign div_out_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (div_out_ready) begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_out_ready) begin
            out_reg <= out_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // input backpressure only when the whole pipe is full and stalled
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without a stalled output");

    a_par_point: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.parallel) |->
            (m_data.cross_x == '1 && m_data.cross_y == '1 && !m_data.clipped))
        else $error("parallel result without (-1,-1)");

    a_clip_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clipped) |->
            (m_data.cross_x == {1'b1, {(COORD_BITS-1){1'b0}}}
             || m_data.cross_x == {1'b0, {(COORD_BITS-1){1'b1}}}
             || m_data.cross_y == {1'b1, {(COORD_BITS-1){1'b0}}}
             || m_data.cross_y == {1'b0, {(COORD_BITS-1){1'b1}}}))
        else $error("clipped result not at a range limit");

endmodule
